// ----- sv/assert_macros.svh -----
// assertion macros for the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define CHK_IMPL(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("check failed");
`define CHK_NEXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("check failed");
`endif

// ----- sv/iqws_pkg.sv -----
package iqws_pkg;
  localparam int Depth = 16;
  localparam int IdxW = 4;
  localparam logic [2:0] CMD_INSERT = 3'd0;
  localparam logic [2:0] CMD_WAKEUP = 3'd1;
  localparam logic [2:0] CMD_ALU1 = 3'd2;
  localparam logic [2:0] CMD_ALU2 = 3'd3;
  localparam logic [2:0] CMD_FP = 3'd4;
  localparam logic [2:0] CMD_FLUSH = 3'd5;
  // spare command codes, no effect on the queue
  localparam logic [2:0] CMD_SPARE_A = 3'd6;
  localparam logic [2:0] CMD_SPARE_B = 3'd7;
  localparam logic [2:0] KIND_BRANCH = 3'd0;

  typedef struct packed {
    logic       used;
    logic [2:0] kind;
    logic [5:0] src_a;
    logic [5:0] src_b;
    logic [5:0] dest;
    logic [4:0] tag;
    logic       a_rdy;
    logic       b_rdy;
  } entry_t;

  // per-cell match flags handed to the selector
  typedef struct packed {
    logic br_rdy;
    logic ar_rdy;
    logic fp_rdy;
    logic br_tag;
    logic ar_tag;
  } match_t;

  // control broadcast to the row of cells
  typedef struct packed {
    logic       wake;
    logic [5:0] woken_reg;
    logic       do_remove;
    logic [IdxW-1:0] rm_idx;
    logic       do_insert;
    logic [IdxW-1:0] ins_idx;
  } cell_ctl_t;
endpackage

// ----- sv/iqws_cell.sv -----
module iqws_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [3:0]          my_idx,
  input  iqws_pkg::cell_ctl_t ctl,
  input  iqws_pkg::entry_t    new_entry,
  input  iqws_pkg::entry_t    upper,
  input  logic [2:0]          fp_kind,
  input  logic [4:0]          flush_tag,
  output iqws_pkg::entry_t    entry,
  output iqws_pkg::match_t    match
);
  iqws_pkg::entry_t ent_r, ent_nxt;
  logic rdy;

  // age-ordered shift, insert and wakeup
  always_comb begin
    ent_nxt = ent_r;
    if (ctl.wake && ent_r.used) begin
      if (ent_r.src_a == ctl.woken_reg) ent_nxt.a_rdy = 1'b1;
      if (ent_r.src_b == ctl.woken_reg) ent_nxt.b_rdy = 1'b1;
    end
    if (ctl.do_remove && my_idx >= ctl.rm_idx) begin
      ent_nxt = upper;
    end
    if (ctl.do_insert && my_idx == ctl.ins_idx) begin
      ent_nxt = new_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r.used <= 1'b0;
    end else begin
      ent_r.used <= ent_nxt.used;
    end
    ent_r.kind  <= ent_nxt.kind;
    ent_r.src_a <= ent_nxt.src_a;
    ent_r.src_b <= ent_nxt.src_b;
    ent_r.dest  <= ent_nxt.dest;
    ent_r.tag   <= ent_nxt.tag;
    ent_r.a_rdy <= ent_nxt.a_rdy;
    ent_r.b_rdy <= ent_nxt.b_rdy;
  end

  // match flags
  assign rdy = ent_r.used && ent_r.a_rdy && ent_r.b_rdy;
  assign entry = ent_r;
  assign match.br_rdy = rdy && (ent_r.kind == iqws_pkg::KIND_BRANCH);
  assign match.ar_rdy = rdy && (ent_r.kind != iqws_pkg::KIND_BRANCH);
  assign match.fp_rdy = match.ar_rdy && (ent_r.kind == fp_kind);
  assign match.br_tag = ent_r.used && (ent_r.kind == iqws_pkg::KIND_BRANCH)
                        && (ent_r.tag == flush_tag);
  assign match.ar_tag = ent_r.used && (ent_r.kind != iqws_pkg::KIND_BRANCH)
                        && (ent_r.tag == flush_tag);
endmodule

// ----- sv/iqws_pick.sv -----
module iqws_pick (
  input  logic [15:0] req,
  output logic        found,
  output logic [3:0]  idx
);
  // oldest (lowest index) requester
  always_comb begin
    found = 1'b0;
    idx = '0;
    for (int i = iqws_pkg::Depth - 1; i >= 0; i--) begin
      if (req[i]) begin
        found = 1'b1;
        idx = 4'(i);
      end
    end
  end
endmodule

// ----- sv/issue_queue_wakeup_select_core.sv -----
// issue queue with wakeup and select, 16 entries in age order
// command channel: a transfer happens when start is high and busy is low;
// in_cmd selects insert, wakeup, issue alu1/alu2/fp or flush, other codes
// change nothing. busy is held low, so one command is taken each cycle.
// result channel: every command gives one result, shown for exactly one
// cycle with out_valid high, in the cycle after the command transfer.
// throughput 1 command per cycle, set by the row of cells which shifts,
// writes and wakes all entries together in the same cycle.
// unused result fields read as zero; out_full_res shows the state after
// the command. the receiver cannot stall the result channel.
// a synchronous reset (rst_n low) empties the queue at once.
module issue_queue_wakeup_select_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] in_cmd,
  input  logic [2:0] in_kind,
  input  logic [5:0] in_src_a,
  input  logic [5:0] in_src_b,
  input  logic [5:0] in_dest,
  input  logic       in_src_a_ready,
  input  logic       in_src_b_ready,
  input  logic [4:0] in_tag,
  input  logic [5:0] in_woken_reg,
  output logic       out_valid,
  output logic       out_full_res,
  output logic       out_issued_valid,
  output logic [2:0] out_issued_kind,
  output logic [5:0] out_issued_src_a,
  output logic [5:0] out_issued_src_b,
  output logic [5:0] out_issued_dest,
  output logic [4:0] out_issued_tag,
  output logic       out_flush_hit,
  output logic       out_freed_valid,
  output logic [5:0] out_freed_reg
);
  localparam int N = iqws_pkg::Depth;
  iqws_pkg::entry_t ents [N];
  iqws_pkg::entry_t ups [N];
  iqws_pkg::match_t m [N];
  iqws_pkg::entry_t new_e, sel_e;
  iqws_pkg::cell_ctl_t ctl;
  logic [N-1:0] br_rdy, ar_rdy, fp_rdy, br_tag, ar_tag;
  logic f_br, f_ar, f_fp, f_bt, f_at;
  logic [3:0] i_br, i_ar, i_fp, i_bt, i_at;
  logic [4:0] held_r, held_nxt;
  logic go, full;
  logic hit;
  logic [3:0] hit_idx;
  logic iss, fl, fl_ar;

  logic       val_r, full_r, iss_r, fl_r, fr_r;
  logic [2:0] kind_r;
  logic [5:0] sa_r, sb_r, dst_r, frreg_r;
  logic [4:0] tag_r;

  assign busy = 1'b0;
  assign go = start && !busy;
  assign full = (held_r == 5'(N));

  assign new_e = '{used: 1'b1, kind: in_kind, src_a: in_src_a, src_b: in_src_b,
                   dest: in_dest, tag: in_tag, a_rdy: in_src_a_ready,
                   b_rdy: in_src_b_ready};

  // row of cells, each fed by its younger neighbour
  for (genvar g = 0; g < N; g++) begin : g_cell
    if (g == N - 1) begin : g_top
      assign ups[g] = '0;
    end else begin : g_mid
      assign ups[g] = ents[g+1];
    end
    iqws_cell u_cell (
      .clk(clk), .rst_n(rst_n), .my_idx(4'(g)), .ctl(ctl), .new_entry(new_e),
      .upper(ups[g]), .fp_kind(in_kind), .flush_tag(in_tag),
      .entry(ents[g]), .match(m[g])
    );
    assign br_rdy[g] = m[g].br_rdy;
    assign ar_rdy[g] = m[g].ar_rdy;
    assign fp_rdy[g] = m[g].fp_rdy;
    assign br_tag[g] = m[g].br_tag;
    assign ar_tag[g] = m[g].ar_tag;
  end

  iqws_pick u_pbr (.req(br_rdy), .found(f_br), .idx(i_br));
  iqws_pick u_par (.req(ar_rdy), .found(f_ar), .idx(i_ar));
  iqws_pick u_pfp (.req(fp_rdy), .found(f_fp), .idx(i_fp));
  iqws_pick u_pbt (.req(br_tag), .found(f_bt), .idx(i_bt));
  iqws_pick u_pat (.req(ar_tag), .found(f_at), .idx(i_at));

  // selection per command
  always_comb begin
    hit = 1'b0;
    hit_idx = '0;
    iss = 1'b0;
    fl = 1'b0;
    fl_ar = 1'b0;
    case (in_cmd)
      iqws_pkg::CMD_ALU1: begin
        iss = f_br || f_ar;
        hit_idx = f_br ? i_br : i_ar;
      end
      iqws_pkg::CMD_ALU2: begin
        iss = f_ar;
        hit_idx = i_ar;
      end
      iqws_pkg::CMD_FP: begin
        iss = f_fp;
        hit_idx = i_fp;
      end
      iqws_pkg::CMD_FLUSH: begin
        fl = f_bt || f_at;
        fl_ar = !f_bt && f_at;
        hit_idx = f_bt ? i_bt : i_at;
      end
      default: ;
    endcase
    hit = iss || fl;
  end

  assign sel_e = ents[hit_idx];

  always_comb begin
    ctl.wake = go && (in_cmd == iqws_pkg::CMD_WAKEUP);
    ctl.woken_reg = in_woken_reg;
    ctl.do_remove = go && hit;
    ctl.rm_idx = hit_idx;
    ctl.do_insert = go && (in_cmd == iqws_pkg::CMD_INSERT) && !full;
    ctl.ins_idx = held_r[3:0];
    held_nxt = held_r;
    if (ctl.do_insert) held_nxt = held_r + 5'd1;
    if (ctl.do_remove) held_nxt = held_r - 5'd1;
  end

  // fill count and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r  <= '0;
      val_r   <= 1'b0;
      full_r  <= 1'b0;
      iss_r   <= 1'b0;
      kind_r  <= '0;
      sa_r    <= '0;
      sb_r    <= '0;
      dst_r   <= '0;
      tag_r   <= '0;
      fl_r    <= 1'b0;
      fr_r    <= 1'b0;
      frreg_r <= '0;
    end else begin
      held_r  <= held_nxt;
      val_r   <= go;
      full_r  <= (held_nxt == 5'(N));
      iss_r   <= go && iss;
      kind_r  <= (go && iss) ? sel_e.kind : '0;
      sa_r    <= (go && iss) ? sel_e.src_a : '0;
      sb_r    <= (go && iss) ? sel_e.src_b : '0;
      dst_r   <= (go && iss) ? sel_e.dest : '0;
      tag_r   <= (go && iss) ? sel_e.tag : '0;
      fl_r    <= go && fl;
      fr_r    <= go && fl_ar;
      frreg_r <= (go && fl_ar) ? sel_e.dest : '0;
    end
  end

  assign out_valid = val_r;
  assign out_full_res = full_r;
  assign out_issued_valid = iss_r;
  assign out_issued_kind = kind_r;
  assign out_issued_src_a = sa_r;
  assign out_issued_src_b = sb_r;
  assign out_issued_dest = dst_r;
  assign out_issued_tag = tag_r;
  assign out_flush_hit = fl_r;
  assign out_freed_valid = fr_r;
  assign out_freed_reg = frreg_r;
endmodule

// ----- sv/iqws_checker.sv -----
`include "assert_macros.svh"
module iqws_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic [2:0] in_cmd,
  input logic       out_valid,
  input logic       out_issued_valid,
  input logic       out_flush_hit,
  input logic       out_freed_valid,
  input logic [5:0] out_freed_reg
);
  `CHK_NEXT(a_one_result, clk, rst_n, start && !busy, out_valid)
  `CHK_IMPL(a_no_stray, clk, rst_n, !out_valid,
            !out_issued_valid && !out_flush_hit)
  `CHK_IMPL(a_freed_hit, clk, rst_n, out_freed_valid, out_flush_hit)
  `CHK_NEXT(a_wake_quiet, clk, rst_n, start && !busy && in_cmd == iqws_pkg::CMD_WAKEUP,
            !out_issued_valid && !out_flush_hit)
  `CHK_IMPL(a_freed_zero, clk, rst_n, !out_freed_valid, out_freed_reg == 6'd0)
endmodule

bind issue_queue_wakeup_select_core iqws_checker u_chk (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_cmd(in_cmd),
  .out_valid(out_valid), .out_issued_valid(out_issued_valid),
  .out_flush_hit(out_flush_hit), .out_freed_valid(out_freed_valid),
  .out_freed_reg(out_freed_reg)
);
